FILE: rtl/ert_pkg.sv
// shared types and constants for the echo request tracker
// no dependencies; imported by every rtl module of the tracker
package ert_pkg;

  // fixed field widths
  localparam int SLOT_W    = 6;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  // command codes
  localparam logic [1:0] CMD_REPLY = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_PORT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = CFG_IDX_W'(1);

  // register reset values
  localparam logic [15:0] ECHO_PORT_RST = 16'd10013;
  localparam logic [31:0] TIMEOUT_RST   = 32'd3100000000;

  // result kinds
  typedef enum logic [2:0] {
    KIND_REPLY_SEND = 3'd0,
    KIND_TIMEOUT    = 3'd1,
    KIND_FIRST      = 3'd2,
    KIND_BAD_PORT   = 3'd3,
    KIND_BAD_INDEX  = 3'd4,
    KIND_BAD_MAGIC  = 3'd5
  } kind_t;

  // input word
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] reply_port;
    logic [31:0] ctx_index;
    logic [63:0] reply_magic;
    logic [63:0] now;
  } in_word_t;

  // result word
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       send_magic;
    logic [31:0]       reply_total;
    logic [31:0]       drop_total;
    logic              last;
  } out_word_t;

  // one slot table entry
  typedef struct packed {
    logic [63:0] magic;
    logic [63:0] sent;
  } slot_entry_t;

endpackage

FILE: rtl/ert_slot_mem.sv
// slot table: magic and last-send time per slot, one write and one read port
// depends on ert_pkg; per-entry valid bits make unwritten entries read as zero
module ert_slot_mem import ert_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_entry_t   rd_entry,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_entry_t   wr_entry
);

  slot_entry_t      mem [DEPTH];
  logic [DEPTH-1:0] vld;

  // valid bits, cleared at once by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // registered read, entries never written read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

FILE: rtl/ert_result_buf.sv
// one-entry output register between the tracker core and the result channel
// depends on ert_pkg for the result word type
module ert_result_buf import ert_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  out_word_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // a new word may enter when empty or when the held word leaves
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_word <= in_word;
    end
  end

endmodule

FILE: rtl/echo_request_tracker_with_timeout.sv
// echo request tracker: reply and start read the slot; check waits for the output buffer
// tick scan reads one slot per cycle from the table but holds on a due slot while output stalls
// cmd 3 is dropped in idle; slot read-modify-writes use the one read port and one write port
// reset is synchronous: counters clear, registers load defaults, slot valid bits clear at once
// no clearing pass after reset, the block takes words on the first cycle out of reset
module echo_request_tracker_with_timeout import ert_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t            state, state_next;
  in_word_t          req;
  logic [IDX_W-1:0]  sp, sp_next;
  logic              hold_valid, hold_valid_next;
  logic [SLOT_W-1:0] hold_slot, hold_slot_next;
  logic [63:0]       hold_magic, hold_magic_next;
  logic [31:0]       hold_drop, hold_drop_next;
  logic [31:0]       reply_cnt, reply_cnt_next;
  logic [31:0]       timeout_cnt, timeout_cnt_next;
  logic [15:0]       match_port;
  logic [31:0]       timeout_ticks;

  logic              in_fire, cfg_fire;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  slot_entry_t       rd_entry, wr_entry;
  logic              emit, buf_ready;
  out_word_t         emit_word;
  logic              in_idx_ok, req_idx_ok, due;
  logic [IDX_W-1:0]  req_idx;
  logic [63:0]       age;
  logic [31:0]       drop_inc, reply_inc;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // index checks and slot arithmetic
  assign in_idx_ok  = in_data.ctx_index < 32'(SLOTS);
  assign req_idx_ok = req.ctx_index < 32'(SLOTS);
  assign req_idx    = req.ctx_index[IDX_W-1:0];
  assign age        = req.now - rd_entry.sent;
  assign due        = age >= {32'd0, timeout_ticks};
  assign drop_inc   = (timeout_cnt == '1) ? timeout_cnt : timeout_cnt + 32'd1;
  assign reply_inc  = (reply_cnt == '1) ? reply_cnt : reply_cnt + 32'd1;

  // sequencer
  always_comb begin
    state_next       = state;
    sp_next          = sp;
    hold_valid_next  = hold_valid;
    hold_slot_next   = hold_slot;
    hold_magic_next  = hold_magic;
    hold_drop_next   = hold_drop;
    reply_cnt_next   = reply_cnt;
    timeout_cnt_next = timeout_cnt;
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = req_idx;
    wr_entry         = '{magic: rd_entry.magic, sent: req.now};
    emit             = 1'b0;
    emit_word        = '{kind: KIND_BAD_PORT, slot: '0, send_magic: '0,
                         reply_total: reply_cnt, drop_total: timeout_cnt, last: 1'b1};
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.cmd)
            CMD_REPLY, CMD_START: begin
              rd_en      = 1'b1;
              rd_addr    = in_idx_ok ? in_data.ctx_index[IDX_W-1:0] : '0;
              state_next = ST_CHECK;
            end
            CMD_TICK: begin
              rd_en      = 1'b1;
              sp_next    = '0;
              state_next = ST_SCAN;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        if (buf_ready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (req.cmd == CMD_REPLY && req.reply_port != match_port) begin
            emit_word.kind = KIND_BAD_PORT;
          end else if (!req_idx_ok) begin
            emit_word.kind = KIND_BAD_INDEX;
          end else if (req.cmd == CMD_START) begin
            emit_word.kind = KIND_FIRST;
            emit_word.slot = SLOT_W'(req_idx);
            wr_en          = 1'b1;
            wr_entry.magic = '0;
          end else if (req.reply_magic != rd_entry.magic) begin
            emit_word.kind = KIND_BAD_MAGIC;
            emit_word.slot = SLOT_W'(req_idx);
          end else begin
            emit_word.kind        = KIND_REPLY_SEND;
            emit_word.slot        = SLOT_W'(req_idx);
            emit_word.send_magic  = rd_entry.magic + 64'd1;
            emit_word.reply_total = reply_inc;
            reply_cnt_next        = reply_inc;
            wr_en                 = 1'b1;
            wr_entry.magic        = rd_entry.magic + 64'd1;
          end
        end
      end
      ST_SCAN: begin
        // a due slot pushes the previously held timeout word out first
        if (!due || !hold_valid || buf_ready) begin
          if (due) begin
            emit                  = hold_valid;
            emit_word.kind        = KIND_TIMEOUT;
            emit_word.slot        = hold_slot;
            emit_word.send_magic  = hold_magic;
            emit_word.drop_total  = hold_drop;
            emit_word.last        = 1'b0;
            wr_en                 = 1'b1;
            wr_addr               = sp;
            timeout_cnt_next      = drop_inc;
            hold_valid_next       = 1'b1;
            hold_slot_next        = SLOT_W'(sp);
            hold_magic_next       = rd_entry.magic;
            hold_drop_next        = drop_inc;
          end
          if (sp == LAST_SLOT) begin
            state_next = ST_FLUSH;
          end else begin
            sp_next = sp + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = sp + IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        // last timeout word of the scan carries the end mark
        if (!hold_valid) begin
          state_next = ST_IDLE;
        end else if (buf_ready) begin
          emit                 = 1'b1;
          emit_word.kind       = KIND_TIMEOUT;
          emit_word.slot       = hold_slot;
          emit_word.send_magic = hold_magic;
          emit_word.drop_total = hold_drop;
          emit_word.last       = 1'b1;
          hold_valid_next      = 1'b0;
          state_next           = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      hold_valid  <= 1'b0;
      reply_cnt   <= '0;
      timeout_cnt <= '0;
    end else begin
      state       <= state_next;
      hold_valid  <= hold_valid_next;
      reply_cnt   <= reply_cnt_next;
      timeout_cnt <= timeout_cnt_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req <= in_data;
    end
    sp         <= sp_next;
    hold_slot  <= hold_slot_next;
    hold_magic <= hold_magic_next;
    hold_drop  <= hold_drop_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_port    <= ECHO_PORT_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_fire) begin
      if (cfg_index == REG_ECHO_PORT) begin
        match_port <= cfg_data[15:0];
      end
      if (cfg_index == REG_TIMEOUT) begin
        timeout_ticks <= cfg_data;
      end
    end
  end

  ert_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  ert_result_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (emit),
    .in_ready  (buf_ready),
    .in_word   (emit_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_data)
  );

  // counters only move up
  a_reply_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> reply_cnt >= $past(reply_cnt))
    else $error("reply counter went down");

  a_drop_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> timeout_cnt >= $past(timeout_cnt))
    else $error("drop counter went down");

  // the end mark closes the item
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    emit && emit_word.last |=> state == ST_IDLE)
    else $error("end-marked word did not finish the item");

  // no held timeout word survives into idle
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !hold_valid)
    else $error("held timeout word lost");

  // scan pointer stays inside the table
  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> sp <= LAST_SLOT)
    else $error("scan pointer out of range");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// testbench for echo_request_tracker_with_timeout: directed, random and backpressure tests
// predicts every result word from its own copy of the slot table; needs rtl/ert_pkg.sv and the rtl
module tb;
  import ert_pkg::*;

  localparam int SLOT_COUNT     = 32;
  localparam int DRAIN_CYCLES   = 2 * SLOT_COUNT + 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // tracker copy used for prediction
  logic [63:0] magic_tbl [SLOT_COUNT];
  logic [63:0] stamp_tbl [SLOT_COUNT];
  logic [31:0] reply_count;
  logic [31:0] drop_count;
  logic [15:0] match_port_cfg;
  logic [31:0] timeout_cfg;
  out_word_t   pending_results [$];

  // stimulus and checker controls
  logic [63:0] clock_now;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  echo_request_tracker_with_timeout #(
    .SLOTS(SLOT_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // result word built from the current counters
  function automatic out_word_t make_result(kind_t k, int s, logic [63:0] m, logic l);
    out_word_t r;
    r.kind        = k;
    r.slot        = SLOT_W'(s);
    r.send_magic  = m;
    r.reply_total = reply_count;
    r.drop_total  = drop_count;
    r.last        = l;
    return r;
  endfunction

  // update the tracker copy with one accepted word and queue its results
  function automatic void predict_results(in_word_t w);
    logic [SLOT_COUNT-1:0] due;
    int s;
    int n_due;
    int n_done;
    s = int'(w.ctx_index[SLOT_W-1:0]);
    case (w.cmd)
      CMD_REPLY: begin
        if (w.reply_port != match_port_cfg) begin
          pending_results.push_back(make_result(KIND_BAD_PORT, 0, 64'd0, 1'b1));
        end else if (w.ctx_index >= SLOT_COUNT) begin
          pending_results.push_back(make_result(KIND_BAD_INDEX, 0, 64'd0, 1'b1));
        end else if (w.reply_magic != magic_tbl[s]) begin
          pending_results.push_back(make_result(KIND_BAD_MAGIC, s, 64'd0, 1'b1));
        end else begin
          if (reply_count != '1) reply_count++;
          magic_tbl[s] = magic_tbl[s] + 64'd1;
          stamp_tbl[s] = w.now;
          pending_results.push_back(make_result(KIND_REPLY_SEND, s, magic_tbl[s], 1'b1));
        end
      end
      CMD_TICK: begin
        // find due slots first so last can be placed on the final one
        n_due = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          due[i] = ((w.now - stamp_tbl[i]) >= {32'd0, timeout_cfg});
          if (due[i]) n_due++;
        end
        n_done = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (due[i]) begin
            if (drop_count != '1) drop_count++;
            stamp_tbl[i] = w.now;
            n_done++;
            pending_results.push_back(make_result(KIND_TIMEOUT, i, magic_tbl[i],
                                                  n_done == n_due));
          end
        end
      end
      CMD_START: begin
        if (w.ctx_index >= SLOT_COUNT) begin
          pending_results.push_back(make_result(KIND_BAD_INDEX, 0, 64'd0, 1'b1));
        end else begin
          magic_tbl[s] = 64'd0;
          stamp_tbl[s] = w.now;
          pending_results.push_back(make_result(KIND_FIRST, s, 64'd0, 1'b1));
        end
      end
      default: begin
        // unused command, no result
      end
    endcase
  endfunction

  // compare one result word with the oldest expected one
  function automatic void check_result(out_word_t got);
    out_word_t exp;
    logic bad;
    if (pending_results.size() == 0) begin
      $error("unexpected result word: kind %0d slot %0d", got.kind, got.slot);
      fail_count++;
      return;
    end
    exp = pending_results.pop_front();
    bad = 1'b0;
    if (got.kind !== exp.kind) begin
      $error("kind mismatch: expected %0d, actual %0d", exp.kind, got.kind);
      bad = 1'b1;
    end
    if (got.slot !== exp.slot) begin
      $error("slot mismatch: expected %0d, actual %0d", exp.slot, got.slot);
      bad = 1'b1;
    end
    if (got.send_magic !== exp.send_magic) begin
      $error("send_magic mismatch: expected %h, actual %h", exp.send_magic, got.send_magic);
      bad = 1'b1;
    end
    if (got.reply_total !== exp.reply_total) begin
      $error("reply_total mismatch: expected %0d, actual %0d", exp.reply_total,
             got.reply_total);
      bad = 1'b1;
    end
    if (got.drop_total !== exp.drop_total) begin
      $error("drop_total mismatch: expected %0d, actual %0d", exp.drop_total,
             got.drop_total);
      bad = 1'b1;
    end
    if (got.last !== exp.last) begin
      $error("last mismatch: expected %0d, actual %0d", exp.last, got.last);
      bad = 1'b1;
    end
    if (bad) fail_count++;
  endfunction

  // receiver: check accepted words, then pick the next ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_word_t make_cmd(logic [1:0] c, logic [15:0] p, logic [31:0] i,
                                        logic [63:0] m, logic [63:0] t);
    in_word_t w;
    w.cmd         = c;
    w.reply_port  = p;
    w.ctx_index   = i;
    w.reply_magic = m;
    w.now         = t;
    return w;
  endfunction

  // offer one word, idling first at random; valid stays high after acceptance
  task automatic send_word(in_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_results(w);
  endtask

  // stop offering, wait for every expected word, then let a scan finish
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ECHO_PORT) match_port_cfg = value[15:0];
    else if (idx == REG_TIMEOUT) timeout_cfg = value;
  endtask

  // random word: mostly replies carrying the slot's current magic, some noise
  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    int s;
    pick = $urandom_range(99);
    s = $urandom_range(SLOT_COUNT - 1);
    clock_now = clock_now + $urandom_range(3000);
    if ($urandom_range(49) == 0) clock_now = {$urandom, $urandom};
    w = make_cmd(CMD_REPLY, match_port_cfg, s, magic_tbl[s], clock_now);
    if (pick < 22) begin
      w.reply_port  = 16'($urandom);
      w.reply_magic = {$urandom, $urandom};
      if (pick < 15) begin
        w.cmd = CMD_START;
        if ($urandom_range(9) == 0) w.ctx_index = $urandom;
      end else begin
        w.cmd = CMD_TICK;
        w.ctx_index = $urandom;
      end
    end else if (pick < 78) begin
      // well-formed reply
    end else if (pick < 84) begin
      w.reply_port = 16'($urandom);
    end else if (pick < 89) begin
      w.ctx_index = $urandom_range(1) ? $urandom : SLOT_COUNT + $urandom_range(31);
    end else if (pick < 95) begin
      w.reply_magic = $urandom_range(1) ? {$urandom, $urandom} : magic_tbl[s] + 64'd1;
    end else begin
      w = make_cmd(CMD_UNUSED, 16'($urandom), $urandom, {$urandom, $urandom}, clock_now);
    end
    return w;
  endfunction

  task automatic test_start_and_reply();
    send_word(make_cmd(CMD_START, 16'h0000, 32'd0, 64'd0, 64'd100));
    send_word(make_cmd(CMD_START, 16'hFFFF, SLOT_COUNT - 1, '1, '1));
    send_word(make_cmd(CMD_START, 16'h0000, SLOT_COUNT, 64'd0, 64'd110));
    send_word(make_cmd(CMD_START, 16'h0000, 32'hFFFF_FFFF, 64'd0, 64'd120));
    send_word(make_cmd(CMD_REPLY, ECHO_PORT_RST, 32'd0, 64'd0, 64'd200));
    send_word(make_cmd(CMD_REPLY, ECHO_PORT_RST, 32'd0, 64'd1, 64'd210));
    // restart of an active slot clears its magic
    send_word(make_cmd(CMD_START, 16'h0000, 32'd0, 64'd0, 64'd300));
    send_word(make_cmd(CMD_REPLY, ECHO_PORT_RST, 32'd0, 64'd0, 64'd310));
  endtask

  task automatic test_bad_words();
    send_word(make_cmd(CMD_REPLY, ECHO_PORT_RST, 32'd0, 64'd0, 64'd320));
    send_word(make_cmd(CMD_REPLY, ECHO_PORT_RST, SLOT_COUNT - 1, '1, 64'd330));
    send_word(make_cmd(CMD_REPLY, ECHO_PORT_RST, 32'hFFFF_FFFF, 64'd0, 64'd340));
    send_word(make_cmd(CMD_REPLY, 16'hFFFF, 32'hFFFF_FFFF, '1, 64'd350));
    send_word(make_cmd(CMD_REPLY, 16'h0000, 32'd1, 64'd0, 64'd360));
    send_word(make_cmd(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, '1, '1));
  endtask

  task automatic test_tick_scan();
    // nothing due yet, then a large age for every slot but the last
    send_word(make_cmd(CMD_TICK, 16'h0000, 32'd0, 64'd0, 64'd1000));
    send_word(make_cmd(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, '1, '1));
  endtask

  task automatic test_register_extremes();
    set_reg(REG_TIMEOUT, 32'd0);
    send_word(make_cmd(CMD_TICK, 16'h0000, 32'd0, 64'd0, 64'd5));
    set_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    send_word(make_cmd(CMD_TICK, 16'h0000, 32'd0, 64'd0, 64'd5 + 64'hFFFF_FFFE));
    send_word(make_cmd(CMD_TICK, 16'h0000, 32'd0, 64'd0, 64'd5 + 64'hFFFF_FFFF));
    set_reg(REG_ECHO_PORT, 32'd0);
    send_word(make_cmd(CMD_REPLY, 16'h0000, 32'd3, magic_tbl[3], 64'd2000));
    send_word(make_cmd(CMD_REPLY, ECHO_PORT_RST, 32'd3, magic_tbl[3], 64'd2010));
    set_reg(REG_ECHO_PORT, 32'hFFFF_FFFF);
    send_word(make_cmd(CMD_REPLY, 16'hFFFF, 32'd4, magic_tbl[4], 64'd2020));
    set_reg(REG_ECHO_PORT, 32'(ECHO_PORT_RST));
    set_reg(REG_TIMEOUT, TIMEOUT_RST);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall);
    set_reg(REG_ECHO_PORT, $urandom);
    set_reg(REG_TIMEOUT, ($urandom_range(3) == 0) ? $urandom : $urandom_range(500, 6000));
    sender_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (count) send_word(random_word());
  endtask

  // long receiver hold while the sender keeps offering words
  task automatic test_output_hold();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_asked++;
    repeat (50) send_word(random_word());
  endtask

  // sender waits for every expected word mid-stream
  task automatic test_sender_pause();
    sender_idle_pct = 20;
    stall_pct = 20;
    repeat (20) send_word(random_word());
    wait_drained();
    repeat (20) send_word(random_word());
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      magic_tbl[i] = 64'd0;
      stamp_tbl[i] = 64'd0;
    end
    reply_count    = 32'd0;
    drop_count     = 32'd0;
    match_port_cfg = ECHO_PORT_RST;
    timeout_cfg    = TIMEOUT_RST;
    clock_now      = 64'd10000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_start_and_reply();
    test_bad_words();
    test_tick_scan();
    test_register_extremes();
    test_random_traffic(95, 0, 0);
    test_random_traffic(95, 67, 0);
    test_random_traffic(95, 0, 67);
    test_random_traffic(95, 20, 20);
    test_output_hold();
    test_sender_pause();

    wait_drained();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
